>>> src/dda_line_rasterizer_unit_defines.svh
// ----------------------------------------------------------------------------
// DDA line rasterizer assertion macros
// Clocked assertion helpers shared by the rasterizer RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define DDA_LINE_RASTERIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Plain clocked property, checked outside reset.
`define DLR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Same-cycle implication.
`define DLR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define DLR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DLR_ASSERT(lbl, prop, msg)
`define DLR_ASSERT_IMPL(lbl, ante, cons, msg)
`define DLR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/dlr_pkg.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Widths, codes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package dlr_pkg;

	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 16;
	localparam int ACC_BITS   = COORD_BITS + 1 + FRAC_BITS;
	localparam int INC_BITS   = FRAC_BITS + 2;
	localparam int LEFT_BITS  = COORD_BITS + 1;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int DIV_BITS   = COORD_BITS + FRAC_BITS + 1;
	localparam int CNT_BITS   = $clog2(DIV_BITS);

	localparam logic KIND_LINE    = 1'b0;
	localparam logic KIND_ADVANCE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_LOAD,
		ST_PLOT
	} state_t;

	typedef struct packed {
		logic start;    // latch endpoints, set up the dividers
		logic div_step; // one quotient bit on both lanes
		logic load;     // load accumulators, increments, pixel count
		logic emit;     // register the current pixel and advance
	} cmd_t;

	typedef struct packed {
		logic active;   // pixels still to be given
		logic div_last; // final divider iteration
		logic out_busy; // result register full and stalled
	} status_t;

endpackage

`default_nettype wire

>>> src/dlr_ctrl.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer controller
// Sequences line setup (divide, load, first pixel) and pixel advances.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dda_line_rasterizer_unit_defines.svh"

module dlr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            kind,
	output logic                 in_stall,
	input  wire dlr_pkg::status_t status_i,
	output dlr_pkg::cmd_t        cmd_o
);
	import dlr_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_LINE) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (status_i.div_last) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_PLOT;
			end
			ST_PLOT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_o    = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = status_i.out_busy;
				if (in_valid && !status_i.out_busy) begin
					if (kind == KIND_LINE) begin
						cmd_o.start = 1'b1;
					end else if (status_i.active) begin
						cmd_o.emit = 1'b1;
					end
				end
			end
			ST_DIVIDE: begin
				cmd_o.div_step = 1'b1;
			end
			ST_LOAD: begin
				cmd_o.load = 1'b1;
			end
			ST_PLOT: begin
				cmd_o.emit = 1'b1;
			end
			default: begin
				cmd_o = '0;
			end
		endcase
	end

	`DLR_ASSERT_NEXT(a_start_divides, cmd_o.start, state_q == ST_DIVIDE,
		"start must enter divide")
	`DLR_ASSERT_NEXT(a_div_done_loads, (state_q == ST_DIVIDE) && status_i.div_last,
		state_q == ST_LOAD, "divide end must load")
	`DLR_ASSERT_NEXT(a_load_then_plot, cmd_o.load, cmd_o.emit,
		"load must be followed by first pixel")

endmodule

`default_nettype wire

>>> src/dlr_datapath.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer datapath
// Two restoring dividers, accumulators, pixel rounding and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dda_line_rasterizer_unit_defines.svh"

module dlr_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire dlr_pkg::cmd_t                cmd_i,
	output dlr_pkg::status_t                  status_o,
	input  wire logic [dlr_pkg::COORD_BITS-1:0] x_start,
	input  wire logic [dlr_pkg::COORD_BITS-1:0] y_start,
	input  wire logic [dlr_pkg::COORD_BITS-1:0] x_end,
	input  wire logic [dlr_pkg::COORD_BITS-1:0] y_end,
	input  wire logic                         out_stall,
	output logic                              out_valid,
	output logic [dlr_pkg::COORD_BITS-1:0]    pixel_x,
	output logic [dlr_pkg::COORD_BITS-1:0]    pixel_y,
	output logic                              last
);
	import dlr_pkg::*;

	// Floor of (acc + 0.5), clamped to the coordinate range.
	function automatic logic [COORD_BITS-1:0] round_pix(input logic [ACC_BITS-1:0] acc);
		logic [ACC_BITS:0]   sum;
		logic [COORD_BITS:0] p;
		sum = {acc[ACC_BITS-1], acc} + ((ACC_BITS+1)'(1) << (FRAC_BITS - 1));
		p   = sum[ACC_BITS-1:FRAC_BITS];
		if (sum[ACC_BITS]) begin
			round_pix = '0;
		end else if (p[COORD_BITS]) begin
			round_pix = '1;
		end else begin
			round_pix = p[COORD_BITS-1:0];
		end
	endfunction

	function automatic logic [INC_BITS-1:0] make_incr(input logic [QUO_BITS-1:0] q,
		input logic neg, input logic zero);
		logic [INC_BITS-1:0] mag;
		mag = {1'b0, q};
		if (zero) begin
			make_incr = '0;
		end else if (neg) begin
			make_incr = ~mag + INC_BITS'(1);
		end else begin
			make_incr = mag;
		end
	endfunction

	// Endpoint differences at setup
	logic [COORD_BITS:0]   dx, dy;
	logic [COORD_BITS-1:0] adx, ady, step;

	// Setup and divider registers
	logic [COORD_BITS-1:0] xs_q, ys_q, step_q;
	logic                  negx_q, negy_q, zx_q, zy_q;
	logic [DIV_BITS-1:0]   dvd_x_q, dvd_y_q;
	logic [COORD_BITS-1:0] rem_x_q, rem_y_q;
	logic [QUO_BITS-1:0]   quo_x_q, quo_y_q;
	logic [CNT_BITS-1:0]   cnt_q;

	// Line state
	logic [ACC_BITS-1:0]   acc_x_q, acc_y_q;
	logic [INC_BITS-1:0]   incr_x_q, incr_y_q;
	logic [LEFT_BITS-1:0]  left_q;

	// Result register
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] out_x_q, out_y_q;
	logic                  out_last_q;

	// Divider step
	logic [COORD_BITS:0]   trial_x, trial_y;
	logic                  ge_x, ge_y;
	logic [LEFT_BITS-1:0]  left_dec;

	assign dx   = {1'b0, x_end} - {1'b0, x_start};
	assign dy   = {1'b0, y_end} - {1'b0, y_start};
	assign adx  = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
	assign ady  = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
	assign step = (adx > ady) ? adx : ady;

	assign trial_x  = {rem_x_q, dvd_x_q[DIV_BITS-1]};
	assign trial_y  = {rem_y_q, dvd_y_q[DIV_BITS-1]};
	assign ge_x     = trial_x >= {1'b0, step_q};
	assign ge_y     = trial_y >= {1'b0, step_q};
	assign left_dec = left_q - LEFT_BITS'(1);

	always_ff @(posedge clk) begin
		if (cmd_i.start) begin
			xs_q    <= x_start;
			ys_q    <= y_start;
			step_q  <= step;
			negx_q  <= dx[COORD_BITS];
			negy_q  <= dy[COORD_BITS];
			zx_q    <= (adx == '0);
			zy_q    <= (ady == '0);
			dvd_x_q <= {1'b0, adx, {FRAC_BITS{1'b0}}} + DIV_BITS'(step >> 1);
			dvd_y_q <= {1'b0, ady, {FRAC_BITS{1'b0}}} + DIV_BITS'(step >> 1);
			rem_x_q <= '0;
			rem_y_q <= '0;
			quo_x_q <= '0;
			quo_y_q <= '0;
		end else if (cmd_i.div_step) begin
			dvd_x_q <= dvd_x_q << 1;
			dvd_y_q <= dvd_y_q << 1;
			rem_x_q <= ge_x ? COORD_BITS'(trial_x - {1'b0, step_q}) : trial_x[COORD_BITS-1:0];
			rem_y_q <= ge_y ? COORD_BITS'(trial_y - {1'b0, step_q}) : trial_y[COORD_BITS-1:0];
			quo_x_q <= {quo_x_q[QUO_BITS-2:0], ge_x};
			quo_y_q <= {quo_y_q[QUO_BITS-2:0], ge_y};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			acc_x_q  <= {1'b0, xs_q, {FRAC_BITS{1'b0}}};
			acc_y_q  <= {1'b0, ys_q, {FRAC_BITS{1'b0}}};
			incr_x_q <= make_incr(quo_x_q, negx_q, zx_q);
			incr_y_q <= make_incr(quo_y_q, negy_q, zy_q);
		end else if (cmd_i.emit) begin
			acc_x_q <= acc_x_q + {{(ACC_BITS-INC_BITS){incr_x_q[INC_BITS-1]}}, incr_x_q};
			acc_y_q <= acc_y_q + {{(ACC_BITS-INC_BITS){incr_y_q[INC_BITS-1]}}, incr_y_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.emit) begin
			out_x_q    <= round_pix(acc_x_q);
			out_y_q    <= round_pix(acc_y_q);
			out_last_q <= (left_dec == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_i.start) begin
				cnt_q <= CNT_BITS'(DIV_BITS - 1);
			end else if (cmd_i.div_step) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
			if (cmd_i.load) begin
				left_q <= {1'b0, step_q} + LEFT_BITS'(1);
			end else if (cmd_i.emit) begin
				left_q <= left_dec;
			end
			if (cmd_i.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status_o.active   = (left_q != '0);
	assign status_o.div_last = (cnt_q == '0);
	assign status_o.out_busy = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign pixel_x   = out_x_q;
	assign pixel_y   = out_y_q;
	assign last      = out_last_q;

	`DLR_ASSERT_IMPL(a_emit_into_free_reg, cmd_i.emit, !(out_valid_q && out_stall),
		"pixel would overwrite a stalled result")
	`DLR_ASSERT_NEXT(a_last_matches_count, cmd_i.emit, out_last_q == (left_q == '0),
		"last flag disagrees with pixel count")
	`DLR_ASSERT_NEXT(a_load_has_pixels, cmd_i.load, left_q != '0, "loaded line has no pixels")

endmodule

`default_nettype wire

>>> src/dda_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer unit
// Steps a fixed-point DDA along a line, one pixel per advance transaction while pixels remain.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  ---------------------------------
//  in       sink       in_valid / in_stall   kind, x_start, y_start, x_end, y_end
//  out      source     out_valid / out_stall pixel_x, pixel_y, last
//
//  An advance transaction's pixel is registered at the same edge that takes it.
//  A new-line transaction runs the per-line divide at one quotient bit per cycle
//  on two parallel lanes, then the controller loads the line in its load state
//  and gives the first pixel of the line from its plot state.
//  The result register parts the channels: input is taken while a result is
//  being drained, and held off during line setup and while the result
//  register is stalled.
//  Reset clears the controller, the pixel count and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Input transactions
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           kind,
	input  wire logic [dlr_pkg::COORD_BITS-1:0] x_start,
	input  wire logic [dlr_pkg::COORD_BITS-1:0] y_start,
	input  wire logic [dlr_pkg::COORD_BITS-1:0] x_end,
	input  wire logic [dlr_pkg::COORD_BITS-1:0] y_end,
	// Pixel transactions
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [dlr_pkg::COORD_BITS-1:0]      pixel_x,
	output logic [dlr_pkg::COORD_BITS-1:0]      pixel_y,
	output logic                                last
);
	import dlr_pkg::*;

	// Command and status between sequencer and datapath
	cmd_t    cmd;
	status_t status;

	// Sequencer: accepts transactions, runs the divide and issues pixel steps.
	dlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_stall (in_stall),
		.status_i (status),
		.cmd_o    (cmd)
	);

	// Datapath: dividers, accumulators and the result register.
	dlr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_i     (cmd),
		.status_o  (status),
		.x_start   (x_start),
		.y_start   (y_start),
		.x_end     (x_end),
		.y_end     (y_end),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.last      (last)
	);

endmodule

`default_nettype wire

>>> dv/dda_line_rasterizer_checker.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer pixel checker
// Watches both channels, predicts each pixel from the accepted input
// transactions and compares the pixels that come out, oldest first.
// ----------------------------------------------------------------------------

module dda_line_rasterizer_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire logic                           kind,
	input  wire logic [dlr_pkg::COORD_BITS-1:0] x_start,
	input  wire logic [dlr_pkg::COORD_BITS-1:0] y_start,
	input  wire logic [dlr_pkg::COORD_BITS-1:0] x_end,
	input  wire logic [dlr_pkg::COORD_BITS-1:0] y_end,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire logic [dlr_pkg::COORD_BITS-1:0] pixel_x,
	input  wire logic [dlr_pkg::COORD_BITS-1:0] pixel_y,
	input  wire logic                           last,
	output int                                  mismatches,
	output int                                  pixels_due
);

	import dlr_pkg::*;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  last;
	} pixel_t;

	pixel_t pixel_q[$];

	// Shadow of the line walker
	logic [ACC_BITS-1:0]  acc_x, acc_y;
	logic [INC_BITS-1:0]  incr_x, incr_y;
	logic [LEFT_BITS-1:0] pixels_left;
	logic                 drawing;

	// Per-step increment for one axis: nearest, halves up, signed by d.
	function automatic logic [INC_BITS-1:0] axis_increment(int d, int span);
		longint mag;
		longint q;
		if (d == 0 || span == 0)
			return '0;
		mag = (d < 0) ? -d : d;
		q = ((mag << FRAC_BITS) + span / 2) / span;
		if (d < 0)
			q = -q;
		return q[INC_BITS-1:0];
	endfunction

	// Round half up and saturate to the coordinate range.
	function automatic logic [COORD_BITS-1:0] round_coord(logic [ACC_BITS-1:0] acc);
		longint s;
		s = longint'($signed(acc)) + (longint'(1) << (FRAC_BITS - 1));
		if (s < 0)
			return '0;
		s = s >>> FRAC_BITS;
		if (s > (longint'(1) << COORD_BITS) - 1)
			return '1;
		return s[COORD_BITS-1:0];
	endfunction

	// Queue the current pixel, then advance the walker one step.
	task automatic plot_pixel();
		pixel_t p;
		p.x = round_coord(acc_x);
		p.y = round_coord(acc_y);
		acc_x = acc_x + {{(ACC_BITS-INC_BITS){incr_x[INC_BITS-1]}}, incr_x};
		acc_y = acc_y + {{(ACC_BITS-INC_BITS){incr_y[INC_BITS-1]}}, incr_y};
		pixels_left = pixels_left - LEFT_BITS'(1);
		drawing = (pixels_left != 0);
		p.last = !drawing;
		pixel_q.push_back(p);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		int dx, dy, span;
		if (!arst_n) begin
			acc_x       = '0;
			acc_y       = '0;
			incr_x      = '0;
			incr_y      = '0;
			pixels_left = '0;
			drawing     = 1'b0;
			mismatches  = 0;
			pixel_q.delete();
		end else begin
			// Compare first: a pixel leaving now never belongs to an input taken now.
			if (out_valid && !out_stall) begin
				if (pixel_q.size() == 0) begin
					$error("unexpected pixel (%0d,%0d) last=%0d", pixel_x, pixel_y, last);
					mismatches++;
				end else begin
					want = pixel_q.pop_front();
					if (pixel_x !== want.x) begin
						$error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
						mismatches++;
					end
					if (pixel_y !== want.y) begin
						$error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
						mismatches++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (kind == KIND_LINE) begin
					dx = int'(x_end) - int'(x_start);
					dy = int'(y_end) - int'(y_start);
					span = (dx < 0) ? -dx : dx;
					if (((dy < 0) ? -dy : dy) > span)
						span = (dy < 0) ? -dy : dy;
					acc_x       = {1'b0, x_start, {FRAC_BITS{1'b0}}};
					acc_y       = {1'b0, y_start, {FRAC_BITS{1'b0}}};
					incr_x      = axis_increment(dx, span);
					incr_y      = axis_increment(dy, span);
					pixels_left = LEFT_BITS'(span + 1);
					drawing     = 1'b1;
					plot_pixel();
				end else if (drawing && pixels_left != 0) begin
					plot_pixel();
				end else begin
					drawing = 1'b0;
				end
			end
		end
		pixels_due = pixel_q.size();
	end

endmodule

>>> dv/tb_dda_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer unit testbench
// Drives new-line and advance transactions with random pacing and random
// output stalls; a checker beside the block predicts and compares pixels.
// ----------------------------------------------------------------------------

module tb_dda_line_rasterizer_unit;

	import dlr_pkg::*;

	localparam int     ITEM_COUNT   = 1800;
	localparam int     HOLD_CYCLES  = 300;
	localparam int     DRAIN_CYCLES = 40;
	localparam longint LIMIT_TIME   = 64'd6_000_000;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic                  kind      = KIND_ADVANCE;
	logic [COORD_BITS-1:0] x_start   = '0;
	logic [COORD_BITS-1:0] y_start   = '0;
	logic [COORD_BITS-1:0] x_end     = '0;
	logic [COORD_BITS-1:0] y_end     = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic                  last;

	int   mismatches;
	int   pixels_due;
	int   items_sent  = 0;
	int   burst_left  = 0;
	logic hold_req    = 1'b0;

	dda_line_rasterizer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.x_start   (x_start),
		.y_start   (y_start),
		.x_end     (x_end),
		.y_end     (y_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.last      (last)
	);

	dda_line_rasterizer_checker pixel_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last       (last),
		.mismatches (mismatches),
		.pixels_due (pixels_due)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Offer one transaction at the falling edge and hold it until the block
	// takes it, then either stay in the burst or idle for a random gap.
	task automatic send(input logic k, input logic [COORD_BITS-1:0] xs,
			input logic [COORD_BITS-1:0] ys, input logic [COORD_BITS-1:0] xe,
			input logic [COORD_BITS-1:0] ye);
		@(negedge clk);
		kind     = k;
		x_start  = xs;
		y_start  = ys;
		x_end    = xe;
		y_end    = ye;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// Drop valid and scramble the idle payload; the block must ignore it.
			@(negedge clk);
			in_valid = 1'b0;
			kind     = 1'($urandom);
			x_start  = COORD_BITS'($urandom);
			y_start  = COORD_BITS'($urandom);
			x_end    = COORD_BITS'($urandom);
			y_end    = COORD_BITS'($urandom);
			repeat ($urandom_range(0, 11)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 10);
		end
	endtask

	// Start a line, then request a number of further pixels. The advance
	// payload is random since the block ignores it.
	task automatic draw_line(input logic [COORD_BITS-1:0] xs,
			input logic [COORD_BITS-1:0] ys, input logic [COORD_BITS-1:0] xe,
			input logic [COORD_BITS-1:0] ye, input int advances);
		send(KIND_LINE, xs, ys, xe, ye);
		repeat (advances)
			send(KIND_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
				COORD_BITS'($urandom), COORD_BITS'($urandom));
	endtask

	// Move a coordinate by up to reach either way, clamped to the screen.
	function automatic logic [COORD_BITS-1:0] nudge(logic [COORD_BITS-1:0] c, int reach);
		int v;
		v = int'(c) + int'($urandom_range(0, 2 * reach)) - reach;
		if (v < 0)
			v = 0;
		if (v > (1 << COORD_BITS) - 1)
			v = (1 << COORD_BITS) - 1;
		return v[COORD_BITS-1:0];
	endfunction

	// Receiver: stall on a pattern that changes mode at random,
	// with stretches of no stall at all, and one long hold-off on request.
	initial begin
		stall_mode_t mode;
		int          mode_left;
		int          phase;
		bit          hold_done;
		mode      = STALL_NONE;
		mode_left = 0;
		phase     = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				// Hold off long enough for the block to fill and stall its input.
				hold_done = 1'b1;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode      = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			phase++;
			case (mode)
				STALL_NONE:  out_stall = 1'b0;
				STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
				default:     out_stall = ((phase % 5) >= 3);
			endcase
		end
	end

	initial begin
		bit                    held;
		bit                    paused;
		int                    roll;
		int                    dx, dy, span, advances;
		logic [COORD_BITS-1:0] xs, ys, xe, ye;
		held   = 1'b0;
		paused = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part.
		// Advance with no line in progress: no pixel.
		send(KIND_ADVANCE, '0, '0, '0, '0);
		// Zero-length line: one pixel flagged last, then an advance past the end.
		draw_line(10'd5, 10'd5, 10'd5, 10'd5, 1);
		// Full diagonal, cut short by a new line in the opposite direction.
		draw_line(10'd0, 10'd0, 10'd1023, 10'd1023, 2);
		draw_line(10'd1023, 10'd1023, 10'd0, 10'd0, 0);
		// Anti-diagonals at the corners of the screen.
		draw_line(10'd1023, 10'd0, 10'd0, 10'd1023, 0);
		draw_line(10'd0, 10'd1023, 10'd1023, 10'd0, 0);
		// Vertical line: zero difference on x; draw it out and advance once past.
		draw_line(10'd7, 10'd3, 10'd7, 10'd9, 7);
		// Both axes falling, minor increment rounded; finish and go past the end.
		draw_line(10'd10, 10'd10, 10'd7, 10'd8, 4);
		// Minor increment of one half: the middle pixel rounds half up.
		draw_line(10'd0, 10'd0, 10'd2, 10'd1, 2);

		// Random part: mostly complete lines with random endpoints, some cut
		// short, some overrun, and a few lone transactions as noise.
		while (items_sent < ITEM_COUNT) begin
			if (!held && items_sent >= 600) begin
				// Keep offering advances back to back while the receiver holds off.
				held       = 1'b1;
				hold_req   = 1'b1;
				burst_left = 80;
				draw_line(10'd0, 10'd0, 10'd1023, 10'd300, 60);
				continue;
			end
			if (!paused && items_sent >= 1200) begin
				// Pause until every pending pixel has drained.
				paused = 1'b1;
				@(negedge clk);
				in_valid = 1'b0;
				wait (pixels_due == 0);
				continue;
			end
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send(1'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
					COORD_BITS'($urandom), COORD_BITS'($urandom));
				continue;
			end
			xs = COORD_BITS'($urandom);
			ys = COORD_BITS'($urandom);
			if (roll < 70) begin
				xe = nudge(xs, 8);
				ye = nudge(ys, 8);
			end else if (roll < 90) begin
				xe = nudge(xs, 64);
				ye = nudge(ys, 64);
			end else begin
				xe = COORD_BITS'($urandom);
				ye = COORD_BITS'($urandom);
			end
			dx   = int'(xe) - int'(xs);
			dy   = int'(ye) - int'(ys);
			span = (dx < 0) ? -dx : dx;
			if (((dy < 0) ? -dy : dy) > span)
				span = (dy < 0) ? -dy : dy;
			roll = $urandom_range(0, 9);
			// Long lines are mostly cut short; only a rare one is drawn out.
			if (span > 64 && $urandom_range(0, 29) != 0)
				advances = $urandom_range(0, 12);
			else if (roll < 7)
				advances = span;
			else if (roll < 9)
				advances = span + $urandom_range(1, 3);
			else
				advances = $urandom_range(0, span);
			draw_line(xs, ys, xe, ye, advances);
		end

		// Drain: wait for every pixel, then let the block settle.
		@(negedge clk);
		in_valid = 1'b0;
		wait (pixels_due == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pixels_due == 0)
			$display("tb_dda_line_rasterizer_unit OK");
		else
			$display("tb_dda_line_rasterizer_unit NOT OK");
		$finish;
	end

	// Watchdog
	initial begin
		#(LIMIT_TIME);
		$display("tb_dda_line_rasterizer_unit NOT OK");
		$finish;
	end

endmodule
